@@ sv/eisenstein_integer_divmod_assert.svh @@
// Assertion macros for the Eisenstein integer divider.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef EISENSTEIN_INTEGER_DIVMOD_ASSERT_SVH
`define EISENSTEIN_INTEGER_DIVMOD_ASSERT_SVH
`ifndef SYNTHESIS
`define EIDM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eidm: same-cycle check failed");
`define EIDM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eidm: next-cycle check failed");
`else
`define EIDM_ASSERT_NOW(lbl, ante, cons)
`define EIDM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/eidm_pkg.sv @@
// Shared constants and the neighbor move table of the Eisenstein integer divider.
// Depends on nothing.
package eidm_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int NUM_MOVES = 9;

	// A move adds a = (axx*dx + axy*dy, ayx*dx + ayy*dy) to the remainder and
	// (sqx, sqy) to the quotient. A tie move also takes an equal norm.
	typedef struct packed {
		logic signed [1:0] axx;
		logic signed [1:0] axy;
		logic signed [1:0] ayx;
		logic signed [1:0] ayy;
		logic signed [1:0] sqx;
		logic signed [1:0] sqy;
		logic              tie;
	} move_t;

	localparam move_t MOVE_TABLE [NUM_MOVES] = '{
		'{ 2'sd1, -2'sd1,  2'sd1,  2'sd0, -2'sd1, -2'sd1, 1'b0},
		'{ 2'sd0,  2'sd1, -2'sd1,  2'sd1,  2'sd0,  2'sd1, 1'b0},
		'{-2'sd1,  2'sd0,  2'sd0, -2'sd1,  2'sd1,  2'sd0, 1'b0},
		'{-2'sd1,  2'sd1, -2'sd1,  2'sd0,  2'sd1,  2'sd1, 1'b0},
		'{ 2'sd0, -2'sd1,  2'sd1, -2'sd1,  2'sd0, -2'sd1, 1'b0},
		'{ 2'sd1,  2'sd0,  2'sd0,  2'sd1, -2'sd1,  2'sd0, 1'b0},
		'{ 2'sd1,  2'sd0,  2'sd0,  2'sd1, -2'sd1,  2'sd0, 1'b1},
		'{ 2'sd1, -2'sd1,  2'sd1,  2'sd0, -2'sd1, -2'sd1, 1'b1},
		'{ 2'sd0,  2'sd1, -2'sd1,  2'sd1,  2'sd0,  2'sd1, 1'b1}
	};

endpackage

@@ sv/eisenstein_integer_divmod.sv @@
// Pipelined Euclidean division of Eisenstein integers x + y*w.
// Depends on eidm_pkg and on the assertion macros in eisenstein_integer_divmod_assert.svh.
`include "eisenstein_integer_divmod_assert.svh"

// A transaction enters whenever start is high; busy never rises, so a new
// division can be issued every clock cycle. Each transaction comes back as a
// one-cycle pulse on done with the quotient, the least-norm remainder and the
// div_zero flag. The receiver cannot stall the block, so it must capture every
// result in the cycle that done is high. Most of the pipeline is the restoring
// divider, which resolves one quotient bit per stage over COORD_WIDTH + 2
// stages, and the nine neighbor moves, each of which takes a multiply stage
// and a compare-and-update stage. A zero denominator returns a zero quotient,
// the sign-extended numerator as remainder, and div_zero high.
module eisenstein_integer_divmod
	import eidm_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] num_x,
	input  logic signed [COORD_WIDTH-1:0] num_y,
	input  logic signed [COORD_WIDTH-1:0] den_x,
	input  logic signed [COORD_WIDTH-1:0] den_y,
	output logic                          done,
	output logic signed [COORD_WIDTH:0]   quot_x,
	output logic signed [COORD_WIDTH:0]   quot_y,
	output logic signed [COORD_WIDTH:0]   rem_x,
	output logic signed [COORD_WIDTH:0]   rem_y,
	output logic                          div_zero
);

	localparam int W   = COORD_WIDTH;
	localparam int PW  = 2 * W;        // one coordinate product
	localparam int AW  = 2 * W + 2;    // sums of products
	localparam int NW  = 2 * W;        // denominator norm
	localparam int QW  = W + 2;        // quotient magnitude and signed quotient
	localparam int PRW = NW + 1;       // divisor and partial remainder
	localparam int DDW = 2 * W + 2;    // rounded dividend
	localparam int RW  = W + 2;        // remainder coordinates
	localparam int UW  = RW + 2;       // 2r - r' terms of the norm difference
	localparam int AXW = W + 1;        // move vector coordinates
	localparam int MPW = AXW + UW;     // move products
	localparam int DLW = MPW + 2;      // norm difference
	localparam int NMV = NUM_MOVES;

	typedef struct packed {
		logic signed [W-1:0] nx;
		logic signed [W-1:0] ny;
		logic signed [W-1:0] dx;
		logic signed [W-1:0] dy;
		logic                zero;
	} pay_t;

	function automatic logic signed [AXW-1:0] cmul(logic signed [1:0] c, logic signed [W-1:0] v);
		logic signed [AXW-1:0] r;
		if (c == 2'sd1) begin
			r = AXW'(v);
		end else if (c == -2'sd1) begin
			r = -AXW'(v);
		end else begin
			r = '0;
		end
		return r;
	endfunction

	assign busy = 1'b0;

	// Stage 1: all coordinate products, straight from the ports.
	logic                 vld_s1;
	pay_t                 pay_s1;
	logic signed [PW-1:0] p_nxdx_s1, p_nydy_s1, p_nxdy_s1, p_nydx_s1;
	logic signed [PW-1:0] p_dxdx_s1, p_dydy_s1, p_dxdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		pay_s1    <= '{nx: num_x, ny: num_y, dx: den_x, dy: den_y,
			zero: (den_x == '0) && (den_y == '0)};
		p_nxdx_s1 <= num_x * den_x;
		p_nydy_s1 <= num_y * den_y;
		p_nxdy_s1 <= num_x * den_y;
		p_nydx_s1 <= num_y * den_x;
		p_dxdx_s1 <= den_x * den_x;
		p_dydy_s1 <= den_y * den_y;
		p_dxdy_s1 <= den_x * den_y;
	end

	// Stage 2: the two coordinates of num * conj(den) and the norm of den.
	logic                 vld_s2;
	pay_t                 pay_s2;
	logic signed [AW-1:0] a_s2, b_s2;
	logic        [NW-1:0] dn_s2;
	logic signed [AW-1:0] dn_full;

	assign dn_full = AW'(p_dxdx_s1) + AW'(p_dydy_s1) - AW'(p_dxdy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pay_s2 <= pay_s1;
		a_s2   <= AW'(p_nxdx_s1) + AW'(p_nydy_s1) - AW'(p_nxdy_s1);
		b_s2   <= AW'(p_nydx_s1) - AW'(p_nxdy_s1);
		dn_s2  <= dn_full[NW-1:0];
	end

	// Stage 3: rounding to nearest becomes floor((2|a| + dn) / (2 dn)).
	// The divider rows are indexed 0..QW; row 0 is this stage.
	logic           dv_vld_s [QW+1];
	pay_t           dv_pay_s [QW+1];
	logic           dv_sa_s  [QW+1];
	logic           dv_sb_s  [QW+1];
	logic [PRW-1:0] dv_dvs_s [QW+1];
	logic [PRW-1:0] dv_rem_a_s [QW+1];
	logic [PRW-1:0] dv_rem_b_s [QW+1];
	logic [QW-1:0]  dv_lq_a_s  [QW+1];
	logic [QW-1:0]  dv_lq_b_s  [QW+1];

	logic [AW-1:0]  mag_a, mag_b;
	logic [DDW-1:0] dvd_a, dvd_b;

	assign mag_a = a_s2[AW-1] ? AW'(-a_s2) : AW'(a_s2);
	assign mag_b = b_s2[AW-1] ? AW'(-b_s2) : AW'(b_s2);
	assign dvd_a = DDW'({mag_a[NW-1:0], 1'b0}) + DDW'(dn_s2);
	assign dvd_b = DDW'({mag_b[NW-1:0], 1'b0}) + DDW'(dn_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= vld_s2;
		end
	end

	// The quotient is known to fit QW bits, so the bits above QW already lie
	// below the divisor and start as the partial remainder.
	always_ff @(posedge clk) begin
		dv_pay_s[0]   <= pay_s2;
		dv_sa_s[0]    <= a_s2[AW-1];
		dv_sb_s[0]    <= b_s2[AW-1];
		dv_dvs_s[0]   <= {dn_s2, 1'b0};
		dv_rem_a_s[0] <= PRW'(dvd_a[DDW-1:QW]);
		dv_rem_b_s[0] <= PRW'(dvd_b[DDW-1:QW]);
		dv_lq_a_s[0]  <= dvd_a[QW-1:0];
		dv_lq_b_s[0]  <= dvd_b[QW-1:0];
	end

	// Restoring divider, one quotient bit per stage in both lanes. Dividend
	// bits leave the top of the low word while quotient bits enter its bottom.
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [PRW:0] t_a, t_b;
		logic         ge_a, ge_b;
		logic [PRW:0] n_a, n_b;

		always_comb begin
			t_a  = {dv_rem_a_s[k], dv_lq_a_s[k][QW-1]};
			t_b  = {dv_rem_b_s[k], dv_lq_b_s[k][QW-1]};
			ge_a = t_a >= {1'b0, dv_dvs_s[k]};
			ge_b = t_b >= {1'b0, dv_dvs_s[k]};
			n_a  = ge_a ? (t_a - {1'b0, dv_dvs_s[k]}) : t_a;
			n_b  = ge_b ? (t_b - {1'b0, dv_dvs_s[k]}) : t_b;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_pay_s[k+1]   <= dv_pay_s[k];
			dv_sa_s[k+1]    <= dv_sa_s[k];
			dv_sb_s[k+1]    <= dv_sb_s[k];
			dv_dvs_s[k+1]   <= dv_dvs_s[k];
			dv_rem_a_s[k+1] <= n_a[PRW-1:0];
			dv_rem_b_s[k+1] <= n_b[PRW-1:0];
			dv_lq_a_s[k+1]  <= {dv_lq_a_s[k][QW-2:0], ge_a};
			dv_lq_b_s[k+1]  <= {dv_lq_b_s[k][QW-2:0], ge_b};
		end
	end

	// Stage 4: signed rough quotient.
	logic                 vld_s4;
	pay_t                 pay_s4;
	logic        [NW-1:0] dn_s4;
	logic signed [QW-1:0] qx_s4, qy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= dv_vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		pay_s4 <= dv_pay_s[QW];
		dn_s4  <= dv_dvs_s[QW][PRW-1:1];
		qx_s4  <= dv_sa_s[QW] ? -$signed(dv_lq_a_s[QW]) : $signed(dv_lq_a_s[QW]);
		qy_s4  <= dv_sb_s[QW] ? -$signed(dv_lq_b_s[QW]) : $signed(dv_lq_b_s[QW]);
	end

	// Stage 5: den * q. The remainder is bounded by the denominator, so only
	// the low RW bits of each product matter.
	logic                 vld_s5;
	pay_t                 pay_s5;
	logic        [NW-1:0] dn_s5;
	logic signed [QW-1:0] qx_s5, qy_s5;
	logic signed [RW-1:0] m_dxqx_s5, m_dyqy_s5, m_dxqy_s5, m_dyqx_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		pay_s5    <= pay_s4;
		dn_s5     <= dn_s4;
		qx_s5     <= qx_s4;
		qy_s5     <= qy_s4;
		m_dxqx_s5 <= RW'(pay_s4.dx * qx_s4);
		m_dyqy_s5 <= RW'(pay_s4.dy * qy_s4);
		m_dxqy_s5 <= RW'(pay_s4.dx * qy_s4);
		m_dyqx_s5 <= RW'(pay_s4.dy * qx_s4);
	end

	// Move rows 0..NMV; row 0 holds the rough remainder.
	logic                 mv_vld_s [NMV+1];
	pay_t                 mv_pay_s [NMV+1];
	logic        [NW-1:0] mv_dn_s  [NMV+1];
	logic signed [QW-1:0] mv_qx_s  [NMV+1];
	logic signed [QW-1:0] mv_qy_s  [NMV+1];
	logic signed [RW-1:0] mv_rx_s  [NMV+1];
	logic signed [RW-1:0] mv_ry_s  [NMV+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_vld_s[0] <= 1'b0;
		end else begin
			mv_vld_s[0] <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		mv_pay_s[0] <= pay_s5;
		mv_dn_s[0]  <= dn_s5;
		mv_qx_s[0]  <= qx_s5;
		mv_qy_s[0]  <= qy_s5;
		mv_rx_s[0]  <= RW'(pay_s5.nx) - m_dxqx_s5 + m_dyqy_s5;
		mv_ry_s[0]  <= RW'(pay_s5.ny) - m_dxqy_s5 - m_dyqx_s5 + m_dyqy_s5;
	end

	// Each move compares N(r + a) with N(r). Since every move vector is the
	// denominator times a unit, N(a) = dn and the difference is
	// ax*(2rx - ry) + ay*(2ry - rx) + dn.
	logic                  mp_vld_s [NMV];
	pay_t                  mp_pay_s [NMV];
	logic         [NW-1:0] mp_dn_s  [NMV];
	logic signed  [QW-1:0] mp_qx_s  [NMV];
	logic signed  [QW-1:0] mp_qy_s  [NMV];
	logic signed  [RW-1:0] mp_rx_s  [NMV];
	logic signed  [RW-1:0] mp_ry_s  [NMV];
	logic signed [AXW-1:0] mp_ax_s  [NMV];
	logic signed [AXW-1:0] mp_ay_s  [NMV];
	logic signed [MPW-1:0] mp_pa_s  [NMV];
	logic signed [MPW-1:0] mp_pb_s  [NMV];

	for (genvar j = 0; j < NMV; j++) begin : g_move
		logic signed [AXW-1:0] ax, ay;
		logic signed  [UW-1:0] u, v;
		logic signed [DLW-1:0] delta;
		logic                  take;

		always_comb begin
			ax = cmul(MOVE_TABLE[j].axx, mv_pay_s[j].dx) + cmul(MOVE_TABLE[j].axy, mv_pay_s[j].dy);
			ay = cmul(MOVE_TABLE[j].ayx, mv_pay_s[j].dx) + cmul(MOVE_TABLE[j].ayy, mv_pay_s[j].dy);
			u  = (UW'(mv_rx_s[j]) <<< 1) - UW'(mv_ry_s[j]);
			v  = (UW'(mv_ry_s[j]) <<< 1) - UW'(mv_rx_s[j]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mp_vld_s[j] <= 1'b0;
			end else begin
				mp_vld_s[j] <= mv_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			mp_pay_s[j] <= mv_pay_s[j];
			mp_dn_s[j]  <= mv_dn_s[j];
			mp_qx_s[j]  <= mv_qx_s[j];
			mp_qy_s[j]  <= mv_qy_s[j];
			mp_rx_s[j]  <= mv_rx_s[j];
			mp_ry_s[j]  <= mv_ry_s[j];
			mp_ax_s[j]  <= ax;
			mp_ay_s[j]  <= ay;
			mp_pa_s[j]  <= ax * u;
			mp_pb_s[j]  <= ay * v;
		end

		always_comb begin
			delta = DLW'(mp_pa_s[j]) + DLW'(mp_pb_s[j]) + DLW'($signed({1'b0, mp_dn_s[j]}));
			take  = delta[DLW-1] || (MOVE_TABLE[j].tie && (delta == '0));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mv_vld_s[j+1] <= 1'b0;
			end else begin
				mv_vld_s[j+1] <= mp_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			mv_pay_s[j+1] <= mp_pay_s[j];
			mv_dn_s[j+1]  <= mp_dn_s[j];
			mv_rx_s[j+1]  <= mp_rx_s[j] + (take ? RW'(mp_ax_s[j]) : RW'(0));
			mv_ry_s[j+1]  <= mp_ry_s[j] + (take ? RW'(mp_ay_s[j]) : RW'(0));
			mv_qx_s[j+1]  <= mp_qx_s[j] + (take ? QW'(MOVE_TABLE[j].sqx) : QW'(0));
			mv_qy_s[j+1]  <= mp_qy_s[j] + (take ? QW'(MOVE_TABLE[j].sqy) : QW'(0));
		end
	end

	// Output register; a zero denominator overrides the computed values.
	logic                done_q;
	logic signed [W:0]   quot_x_q, quot_y_q, rem_x_q, rem_y_q;
	logic                div_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= mv_vld_s[NMV];
		end
	end

	always_ff @(posedge clk) begin
		div_zero_q <= mv_pay_s[NMV].zero;
		if (mv_pay_s[NMV].zero) begin
			quot_x_q <= '0;
			quot_y_q <= '0;
			rem_x_q  <= (W+1)'(mv_pay_s[NMV].nx);
			rem_y_q  <= (W+1)'(mv_pay_s[NMV].ny);
		end else begin
			quot_x_q <= mv_qx_s[NMV][W:0];
			quot_y_q <= mv_qy_s[NMV][W:0];
			rem_x_q  <= mv_rx_s[NMV][W:0];
			rem_y_q  <= mv_ry_s[NMV][W:0];
		end
	end

	assign done     = done_q;
	assign quot_x   = quot_x_q;
	assign quot_y   = quot_y_q;
	assign rem_x    = rem_x_q;
	assign rem_y    = rem_y_q;
	assign div_zero = div_zero_q;

	`EIDM_ASSERT_NOW(a_zero_quot, done && div_zero, quot_x == '0 && quot_y == '0)
	`EIDM_ASSERT_NOW(a_div_entry, dv_vld_s[0] && !dv_pay_s[0].zero, dv_rem_a_s[0] < dv_dvs_s[0] && dv_rem_b_s[0] < dv_dvs_s[0])
	`EIDM_ASSERT_NOW(a_div_exit, dv_vld_s[QW] && !dv_pay_s[QW].zero, dv_rem_a_s[QW] < dv_dvs_s[QW] && dv_rem_b_s[QW] < dv_dvs_s[QW])
	`EIDM_ASSERT_NEXT(a_no_stray_done, !mv_vld_s[NMV], !done)

endmodule
